// ===== design/iss_pkg.sv =====
// shared types and constants for the identifier scanner with symbol table
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package iss_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_ENTERED = 2'd0,
    ST_DIGIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  // classified commands passed from front to back
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] ch;
    logic [5:0] entry_select;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] token_start;
    logic [6:0] token_length;
    logic [3:0] bucket;
    logic [5:0] entry_number;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic [5:0] sel;
  } cmd_item_t;

  // separator characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // decimal digit range
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

// ===== design/identifier_scanner_symbol_table.sv =====
// top level of the identifier scanner with string pool and symbol table
// depends on iss_pkg, iss_front, iss_queue, iss_back
`timescale 1ns / 1ps

// The block splits a character stream into tokens at space, comma, semicolon,
// tab, CR, LF, a flush and an append to a full pool, enters each identifier
// into the next symbol-table entry as (start, length) with a bucket of byte sum
// modulo HASH_BUCKETS, rejects tokens that start with a digit, flags a full
// table, and answers entry reads. One item is taken every cycle while the output
// does not stall: the front registers and classifies the item, a four-deep
// command queue feeds the back, and the back updates the scan state and fills
// the result register for each command, so the sustained rate is one item per
// clock. An entry read gets its data from the symbol-table read port,
// registered on the same edge as the result. The pool and symbol table need no
// clearing pass after reset: only written entries are ever returned, and the
// only pool byte that matters (a token's first character) is tracked as a digit
// flag while the token is open.

module identifier_scanner_symbol_table #(
  parameter int POOL_SIZE    = 128,
  parameter int SYM_ENTRIES  = 64,
  parameter int HASH_BUCKETS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iss_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iss_pkg::out_item_t   out_data
);

  // front to queue
  logic               q_push;
  logic               q_full;
  iss_pkg::cmd_item_t f_cmd;

  // queue to back
  logic               q_pop;
  logic               q_valid;
  iss_pkg::cmd_item_t q_cmd;

  // front stage: classify characters, flush and read items into commands
  iss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (f_cmd)
  );

  // command queue, lets the output side stall without stopping input at once
  iss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (f_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // back stage: pool bookkeeping, close rules, symbol table, result register
  iss_back #(
    .POOL_SIZE    (POOL_SIZE),
    .SYM_ENTRIES  (SYM_ENTRIES),
    .HASH_BUCKETS (HASH_BUCKETS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/iss_front.sv =====
// front end: accepts input items and classifies them into commands
// depends on iss_pkg
`timescale 1ns / 1ps

module iss_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iss_pkg::in_item_t    in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output iss_pkg::cmd_item_t   q_cmd
);

  logic               f_valid_r;
  logic               f_valid_nxt;
  iss_pkg::cmd_item_t f_cmd_r;
  iss_pkg::cmd_item_t f_cmd_nxt;
  logic               f_load;
  logic               f_keep;

  assign q_push   = f_valid_r && !q_full;
  assign in_stall = f_valid_r && q_full;
  assign f_load   = !f_valid_r || !q_full;
  assign q_cmd    = f_cmd_r;

  always_comb begin
    f_cmd_nxt     = f_cmd_r;
    f_cmd_nxt.ch  = in_data.ch;
    f_cmd_nxt.sel = in_data.entry_select;
    f_keep        = 1'b1;
    case (in_data.operation)
      iss_pkg::OP_CHAR: begin
        if (in_data.ch inside {iss_pkg::CH_SPACE, iss_pkg::CH_COMMA, iss_pkg::CH_SEMI,
                               iss_pkg::CH_TAB, iss_pkg::CH_LF, iss_pkg::CH_CR}) begin
          f_cmd_nxt.kind = iss_pkg::CMD_CLOSE;
        end else begin
          f_cmd_nxt.kind = iss_pkg::CMD_APPEND;
        end
      end
      iss_pkg::OP_FLUSH: f_cmd_nxt.kind = iss_pkg::CMD_CLOSE;
      iss_pkg::OP_READ:  f_cmd_nxt.kind = iss_pkg::CMD_READ;
      default: begin
        // unused operation is dropped here
        f_cmd_nxt.kind = iss_pkg::CMD_CLOSE;
        f_keep         = 1'b0;
      end
    endcase
    f_valid_nxt = f_load ? (in_valid && f_keep) : f_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (f_load && in_valid) begin
      f_cmd_r <= f_cmd_nxt;
    end
  end

endmodule

// ===== design/iss_queue.sv =====
// short command queue that decouples front and back
// depends on iss_pkg
`timescale 1ns / 1ps

module iss_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  iss_pkg::cmd_item_t   push_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output iss_pkg::cmd_item_t   head_cmd
);

  localparam int PTRW = $clog2(iss_pkg::QUEUE_DEPTH);
  localparam int CNTW = $clog2(iss_pkg::QUEUE_DEPTH + 1);

  iss_pkg::cmd_item_t slot_r [iss_pkg::QUEUE_DEPTH];
  logic [PTRW-1:0]    wr_ptr_r;
  logic [PTRW-1:0]    rd_ptr_r;
  logic [CNTW-1:0]    count_r;
  logic [CNTW-1:0]    count_nxt;

  assign full       = (count_r == CNTW'(iss_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(iss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(iss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/iss_back.sv =====
// back end: scan state, token close rules, symbol table and result register
// depends on iss_pkg
`timescale 1ns / 1ps

module iss_back #(
  parameter int POOL_SIZE    = 128,
  parameter int SYM_ENTRIES  = 64,
  parameter int HASH_BUCKETS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  iss_pkg::cmd_item_t   q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iss_pkg::out_item_t   out_data
);

  localparam int PW = $clog2(POOL_SIZE);
  localparam int EW = $clog2(SYM_ENTRIES + 1);
  localparam int IW = $clog2(SYM_ENTRIES);
  localparam int BW = $clog2(HASH_BUCKETS);
  localparam int RW = BW + 2;
  localparam int CW = (EW > 6) ? EW : 6;
  // residue correction when the 16-bit sum wraps
  localparam int WRAP_ADJ = (HASH_BUCKETS - (65536 % HASH_BUCKETS)) % HASH_BUCKETS;

  // byte value modulo bucket count
  logic [BW-1:0] cmod_tab [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_cmod
    assign cmod_tab[gi] = BW'(gi % HASH_BUCKETS);
  end

  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] open_r, open_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [BW-1:0] rmod_r, rmod_nxt;
  logic          first_digit_r, first_digit_nxt;
  logic [EW-1:0] count_r, count_nxt;

  logic               s2_valid_r, s2_valid_nxt;
  iss_pkg::out_item_t s2_data_r, s2_data_nxt;
  logic               s2_hit_r, s2_hit_nxt;
  logic [13:0]        rd_data_r;

  logic [13:0]   sym_mem [SYM_ENTRIES];

  logic          s2_ready;
  logic          pool_full;
  logic          is_close;
  logic          is_append;
  logic          is_read;
  logic          tok_empty;
  logic          tbl_full;
  logic          read_hit;
  logic          commit;
  logic [PW-1:0] tok_len;
  logic [16:0]   sum_ext;
  logic [RW-1:0] racc;
  logic [RW-1:0] r1;
  logic [RW-1:0] r2;
  logic          ch_digit;

  assign s2_ready  = !s2_valid_r || !out_stall;
  assign q_pop     = q_valid && s2_ready;

  assign pool_full = (wp_r >= PW'(POOL_SIZE - 1));
  assign is_read   = (q_cmd.kind == iss_pkg::CMD_READ);
  assign is_close  = (q_cmd.kind == iss_pkg::CMD_CLOSE) ||
                     ((q_cmd.kind == iss_pkg::CMD_APPEND) && pool_full);
  assign is_append = (q_cmd.kind == iss_pkg::CMD_APPEND) && !pool_full;
  assign tok_empty = (open_r >= wp_r);
  assign tok_len   = wp_r - open_r;
  assign tbl_full  = (count_r >= EW'(SYM_ENTRIES));
  assign read_hit  = (CW'(q_cmd.sel) < CW'(count_r));
  assign commit    = q_pop && is_close && !tok_empty && !first_digit_r && !tbl_full;
  assign ch_digit  = (q_cmd.ch >= iss_pkg::CH_ZERO) && (q_cmd.ch <= iss_pkg::CH_NINE);

  // running residue of the wrapping sum
  assign sum_ext = {1'b0, sum_r} + 17'(q_cmd.ch);
  assign racc    = RW'(rmod_r) + RW'(cmod_tab[q_cmd.ch]) +
                   (sum_ext[16] ? RW'(WRAP_ADJ) : RW'(0));
  assign r1      = (racc >= RW'(HASH_BUCKETS)) ? racc - RW'(HASH_BUCKETS) : racc;
  assign r2      = (r1 >= RW'(HASH_BUCKETS)) ? r1 - RW'(HASH_BUCKETS) : r1;

  always_comb begin
    wp_nxt          = wp_r;
    open_nxt        = open_r;
    sum_nxt         = sum_r;
    rmod_nxt        = rmod_r;
    first_digit_nxt = first_digit_r;
    count_nxt       = count_r;
    s2_data_nxt     = '0;
    s2_hit_nxt      = 1'b0;
    s2_valid_nxt    = s2_valid_r && out_stall;

    if (q_pop) begin
      if (is_append) begin
        wp_nxt   = wp_r + 1'b1;
        sum_nxt  = sum_ext[15:0];
        rmod_nxt = r2[BW-1:0];
        if (wp_r == open_r) begin
          first_digit_nxt = ch_digit;
        end
      end else if (is_close) begin
        sum_nxt  = '0;
        rmod_nxt = '0;
        if (!tok_empty) begin
          s2_valid_nxt             = 1'b1;
          s2_data_nxt.token_start  = 7'(open_r);
          s2_data_nxt.token_length = 7'(tok_len);
          if (first_digit_r) begin
            s2_data_nxt.status = iss_pkg::ST_DIGIT;
            wp_nxt             = open_r;
          end else if (tbl_full) begin
            s2_data_nxt.status = iss_pkg::ST_FULL;
            s2_data_nxt.bucket = 4'(rmod_r);
            wp_nxt             = open_r;
          end else begin
            s2_data_nxt.status       = iss_pkg::ST_ENTERED;
            s2_data_nxt.bucket       = 4'(rmod_r);
            s2_data_nxt.entry_number = 6'(count_r);
            count_nxt                = count_r + 1'b1;
            open_nxt                 = wp_r;
          end
        end
      end else if (is_read) begin
        s2_valid_nxt             = 1'b1;
        s2_data_nxt.status       = iss_pkg::ST_READ;
        s2_data_nxt.entry_number = q_cmd.sel;
        s2_hit_nxt               = read_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r          <= '0;
      open_r        <= '0;
      sum_r         <= '0;
      rmod_r        <= '0;
      first_digit_r <= 1'b0;
      count_r       <= '0;
      s2_valid_r    <= 1'b0;
    end else begin
      wp_r          <= wp_nxt;
      open_r        <= open_nxt;
      sum_r         <= sum_nxt;
      rmod_r        <= rmod_nxt;
      first_digit_r <= first_digit_nxt;
      count_r       <= count_nxt;
      s2_valid_r    <= s2_valid_nxt;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_data_r <= s2_data_nxt;
      s2_hit_r  <= s2_hit_nxt;
    end
  end

  // symbol table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (commit) begin
      sym_mem[IW'(count_r)] <= {7'(open_r), 7'(tok_len)};
    end
    if (q_pop && is_read) begin
      rd_data_r <= sym_mem[IW'(q_cmd.sel)];
    end
  end

  always_comb begin
    out_data = s2_data_r;
    if (s2_hit_r) begin
      out_data.token_start  = rd_data_r[13:7];
      out_data.token_length = rd_data_r[6:0];
    end
  end

  assign out_valid = s2_valid_r;

  a_commit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> count_r == $past(count_r) + 1'b1)
    else $error("entry count did not advance on commit");

  a_open_order: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= wp_r)
    else $error("open token start beyond write position");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_hit_r) |-> CW'(s2_data_r.entry_number) < CW'(count_r))
    else $error("read hit on an entry never written");

  a_close_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && is_close) |=> (sum_r == '0) && (rmod_r == '0))
    else $error("byte sum not cleared at token close");

endmodule
